### rtl/iem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iem_pkg
// Shared widths, reset values and register codes of the Ising lattice
// energy and magnetization core.
// ----------------------------------------------------------------------------
package iem_pkg;

  // Result and register widths
  localparam int EnergyW  = 23;
  localparam int MagW     = 22;
  localparam int SizeW    = 11;
  localparam int CfgIdxW  = 2;

  // Default lattice capacity
  localparam int DefaultMaxWidth  = 1024;
  localparam int DefaultMaxHeight = 1024;

  // Reset value of both size registers
  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  // Register codes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1
  } cfg_index_e;

endpackage : iem_pkg
`default_nettype wire

### rtl/ising_energy_magnetization_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ising_energy_magnetization_core
// Streaming energy and magnetization of a 2D Ising lattice with periodic
// boundaries, fed one spin bit per item in raster order.
// ----------------------------------------------------------------------------
// The core takes one spin per clock cycle, back to back, with no bubbles
// between rows or lattices, except for the stall named below. Each item
// is registered together with the line-buffer reads for its column (row
// above and stored first row), and when it commits from that register its
// bonds with the left and upper neighbors, plus the horizontal and vertical
// wrap bonds, are added into the accumulators. The result for a lattice
// (energy = minus the bond sum, magnetization = spin sum) is written into
// the output register when the last spin commits from the input register,
// which also catches the line-buffer reads.
// The only stall is a finished result still waiting while the next lattice's
// last spin is ready to complete. The line buffers need no clearing pass:
// an entry is always written in row zero before it is read. Write the size
// registers only while the core is idle; a size of zero counts as one and a
// size above the capacity counts as the capacity.
// ----------------------------------------------------------------------------
module ising_energy_magnetization_core #(
  parameter int MAX_WIDTH  = iem_pkg::DefaultMaxWidth,
  parameter int MAX_HEIGHT = iem_pkg::DefaultMaxHeight
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [iem_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [iem_pkg::SizeW-1:0]         cfg_data_i,
  // spin input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              spin_bit_i,
  // result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [iem_pkg::EnergyW-1:0]     energy_sum_o,
  output logic signed [iem_pkg::MagW-1:0]        magnetization_sum_o
);

  // Counter and compare widths follow the capacity
  localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RCW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW  = (CW + 1  > iem_pkg::SizeW) ? CW + 1  : iem_pkg::SizeW;
  localparam int YW  = (RCW + 1 > iem_pkg::SizeW) ? RCW + 1 : iem_pkg::SizeW;
  localparam int EW  = iem_pkg::EnergyW;
  localparam int MW  = iem_pkg::MagW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [iem_pkg::SizeW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= iem_pkg::SizeReset;
      height_q <= iem_pkg::SizeReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iem_pkg::CfgWidth:  width_q  <= cfg_data_i;
        iem_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Clamp sizes into 1..capacity
  logic [XW-1:0] w_raw, w_eff;
  logic [YW-1:0] h_raw, h_eff;

  always_comb begin
    w_raw = XW'(width_q);
    h_raw = YW'(height_q);
    if (w_raw == '0) begin
      w_eff = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = YW'(1);
    end else if (h_raw > YW'(MAX_HEIGHT)) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: lattice position of the next item
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  col_q;
  logic [RCW-1:0] row_q;
  logic           row_end, last_row;
  logic           in_accept;

  assign row_end  = (XW'(col_q) + XW'(1)) >= w_eff;
  assign last_row = (YW'(row_q) + YW'(1)) >= h_eff;

  // Stage-one item register
  typedef struct packed {
    logic          spin;
    logic [CW-1:0] x;
    logic          x_zero;
    logic          y_zero;
    logic          row_end;
    logic          last_row;
  } s1_item_t;

  s1_item_t s1_q;
  logic     s1_valid_q;
  logic     s1_last, s1_go, s1_commit;
  logic     out_valid_q;

  assign s1_last   = s1_q.row_end && s1_q.last_row;
  // Hold a last site while the previous result still waits
  assign s1_go     = !s1_last || !out_valid_q || out_ready_i;
  assign s1_commit = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
        // Advance the raster position
        if (!row_end) begin
          col_q <= col_q + CW'(1);
        end else begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RCW'(1);
        end
      end else if (s1_commit) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.spin     <= spin_bit_i;
      s1_q.x        <= col_q;
      s1_q.x_zero   <= (col_q == '0);
      s1_q.y_zero   <= (row_q == '0);
      s1_q.row_end  <= row_end;
      s1_q.last_row <= last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: row above and first row, one bit per column
  // ---------------------------------------------------------------------------
  logic above_mem [MAX_WIDTH];
  logic first_mem [MAX_WIDTH];
  logic above_rd_q, first_rd_q;
  logic fwd_above_q, fwd_first_q, fwd_spin_q;

  // Read at acceptance, write at commit
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      above_rd_q <= above_mem[col_q];
      first_rd_q <= first_mem[col_q];
    end
    if (s1_commit) begin
      above_mem[s1_q.x] <= s1_q.spin;
      if (s1_q.y_zero) begin
        first_mem[s1_q.x] <= s1_q.spin;
      end
    end
  end

  // Bypass the write that lands on the same column in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_above_q <= 1'b0;
      fwd_first_q <= 1'b0;
    end else if (in_accept) begin
      fwd_above_q <= s1_valid_q && (s1_q.x == col_q);
      fwd_first_q <= s1_valid_q && (s1_q.x == col_q) && s1_q.y_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      fwd_spin_q <= s1_q.spin;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: bond sum and accumulation
  // ---------------------------------------------------------------------------
  logic                 left_spin_q, row_first_q;
  logic signed [EW-1:0] bond_acc_q;
  logic signed [MW-1:0] spin_acc_q;
  logic                 above_bit, first_bit, row_first_bit;
  logic signed [3:0]    t_left, t_hwrap, t_up, t_vwrap, delta;
  logic signed [EW-1:0] bond_next;
  logic signed [MW-1:0] spin_next;

  always_comb begin
    above_bit     = fwd_above_q ? fwd_spin_q : above_rd_q;
    // Row zero stores its own spin, so a one-row lattice pairs it with itself
    first_bit     = s1_q.y_zero ? s1_q.spin
                                : (fwd_first_q ? fwd_spin_q : first_rd_q);
    row_first_bit = s1_q.x_zero ? s1_q.spin : row_first_q;

    t_left  = s1_q.x_zero  ? 4'sd0 : ((left_spin_q == s1_q.spin) ? 4'sd1 : -4'sd1);
    t_hwrap = s1_q.row_end ? ((row_first_bit == s1_q.spin) ? 4'sd1 : -4'sd1) : 4'sd0;
    t_up    = s1_q.y_zero  ? 4'sd0 : ((above_bit == s1_q.spin) ? 4'sd1 : -4'sd1);
    t_vwrap = s1_q.last_row ? ((first_bit == s1_q.spin) ? 4'sd1 : -4'sd1) : 4'sd0;
    delta   = t_left + t_hwrap + t_up + t_vwrap;

    bond_next = bond_acc_q + EW'(delta);
    spin_next = s1_q.spin ? spin_acc_q + MW'(1) : spin_acc_q - MW'(1);
  end

  logic signed [EW-1:0] energy_q;
  logic signed [MW-1:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_spin_q <= 1'b0;
      row_first_q <= 1'b0;
      bond_acc_q  <= '0;
      spin_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_commit) begin
        if (s1_last) begin
          // Close the lattice and start the next from zero
          left_spin_q <= 1'b0;
          row_first_q <= 1'b0;
          bond_acc_q  <= '0;
          spin_acc_q  <= '0;
        end else begin
          left_spin_q <= s1_q.spin;
          row_first_q <= row_first_bit;
          bond_acc_q  <= bond_next;
          spin_acc_q  <= spin_next;
        end
      end
      if (s1_commit && s1_last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_commit && s1_last) begin
      energy_q <= -bond_next;
      mag_q    <= spin_next;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign energy_sum_o        = energy_q;
  assign magnetization_sum_o = mag_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTH
  // A new result only follows a committed last site
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_commit && s1_last))
    else $error("result raised without a last-site commit");

  // Input stalls only for a last site blocked by a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_last && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  // The column counter stays inside the line buffers
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (XW'(col_q) < XW'(MAX_WIDTH)))
    else $error("column index beyond line buffer depth");
`endif

endmodule : ising_energy_magnetization_core
`default_nettype wire

### verif/ising_energy_magnetization_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_energy_magnetization_core_test
// Self-checking bench for the streaming Ising lattice energy and
// magnetization core. Whole lattices of spin bits are streamed in raster
// order. The sizes cover the degenerate lattices, random small lattices and
// longer single rows and columns. A lattice tracker works out the energy
// and magnetization of every lattice and checks each result as it leaves the
// core. Both handshakes see random bursts of idle and stall cycles, except
// in the closing stretch.
// ----------------------------------------------------------------------------
module ising_energy_magnetization_core_test;
  import iem_pkg::*;

  localparam int MaxW = DefaultMaxWidth;
  localparam int MaxH = DefaultMaxHeight;

  typedef struct packed {
    logic signed [EnergyW-1:0] energy;
    logic signed [MagW-1:0]    mag;
  } lattice_sums_t;

  // spin patterns for whole lattices
  typedef enum int {FillRandom, FillUp, FillDown, FillChecker} fill_e;

  // Tracks the lattice walk of the core and holds the sums still owed by it.
  class lattice_energy_tracker;
    bit              above_row [MaxW];
    bit              first_row [MaxW];
    bit              row_first;
    bit              left;
    int              col;
    int              row;
    bit [EnergyW-1:0] bond_sum;
    bit [MagW-1:0]    spin_sum;
    logic [SizeW-1:0] width_reg  = SizeReset;
    logic [SizeW-1:0] height_reg = SizeReset;
    lattice_sums_t   pending_sums[$];
    int              errors;

    function int eff_size(logic [SizeW-1:0] v, int cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
    endfunction

    function int cur_width();
      return eff_size(width_reg, MaxW);
    endfunction

    function int cur_height();
      return eff_size(height_reg, MaxH);
    endfunction

    function bit [EnergyW-1:0] coupling(bit a, bit b);
      return (a == b) ? 23'd1 : '1;
    endfunction

    function void note_config(cfg_index_e idx, logic [SizeW-1:0] v);
      case (idx)
        CfgWidth:  width_reg  = v;
        CfgHeight: height_reg = v;
        default: ;
      endcase
    endfunction

    function void note_spin(bit s);
      bit            row_end;
      bit            last_row;
      lattice_sums_t sums;
      row_end  = (col + 1 >= cur_width());
      last_row = (row + 1 >= cur_height());
      spin_sum += (s ? 22'd1 : '1);
      if (col == 0) row_first = s;
      else bond_sum += coupling(left, s);
      if (row_end) bond_sum += coupling(s, row_first);
      if (row == 0) first_row[col] = s;
      else bond_sum += coupling(above_row[col], s);
      if (last_row) bond_sum += coupling(s, first_row[col]);
      above_row[col] = s;
      left = s;
      if (!row_end) begin
        col++;
      end else begin
        col = 0;
        if (!last_row) begin
          row++;
        end else begin
          sums.energy = -bond_sum;
          sums.mag    = spin_sum;
          pending_sums.push_back(sums);
          row       = 0;
          bond_sum  = '0;
          spin_sum  = '0;
          row_first = 1'b0;
          left      = 1'b0;
        end
      end
    endfunction

    function void check_sums(logic signed [EnergyW-1:0] e, logic signed [MagW-1:0] m);
      lattice_sums_t want;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got energy_sum %0d magnetization_sum %0d",
                 $time, e, m);
        return;
      end
      want = pending_sums.pop_front();
      if (e !== want.energy) begin
        errors++;
        $display("%0t: energy_sum mismatch: expected %0d, got %0d", $time, want.energy, e);
      end
      if (m !== want.mag) begin
        errors++;
        $display("%0t: magnetization_sum mismatch: expected %0d, got %0d",
                 $time, want.mag, m);
      end
    endfunction

    function int pending();
      return pending_sums.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [SizeW-1:0]          cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      spin_bit_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [EnergyW-1:0] energy_sum_o;
  logic signed [MagW-1:0]    magnetization_sum_o;

  lattice_energy_tracker sb = new();

  // calm: no idling on either side for the closing stretch
  bit calm;
  // in_jitter: per-phase switch for sender gaps, so some phases stream flat out
  bit in_jitter;
  int spins_sent;

  ising_energy_magnetization_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .spin_bit_i          (spin_bit_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .energy_sum_o        (energy_sum_o),
    .magnetization_sum_o (magnetization_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

  // Result side: alternate ready stretches with stall bursts, then hold ready
  // high once the calm stretch starts.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  end

  // Check every result at the edge that moves it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_sums(energy_sum_o, magnetization_sum_o);
    end
  end

  // Send one spin item. Called at a falling edge; returns at the falling edge
  // after the item was taken, with valid still high.
  task automatic send_spin(bit s);
    if (in_jitter && !calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    spin_bit_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_spin(s);
    spins_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every owed result has left the core.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [SizeW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Resize only on an idle core: drain, let the pipeline settle, then write.
  task automatic set_size(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    drain_results();
    repeat (4) @(negedge clk_i);
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
  endtask

  task automatic send_lattice(fill_e fill);
    bit s;
    for (int y = 0; y < sb.cur_height(); y++) begin
      for (int x = 0; x < sb.cur_width(); x++) begin
        case (fill)
          FillUp:      s = 1'b1;
          FillDown:    s = 1'b0;
          FillChecker: s = 1'((x + y) % 2);
          default:     s = 1'($urandom_range(0, 1));
        endcase
        send_spin(s);
      end
    end
  endtask

  // Mostly tiny sizes, now and then a longer side or a zero (counts as one).
  function automatic logic [SizeW-1:0] pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 2) return SizeW'($urandom_range(9, 40));
    return SizeW'($urandom_range(1, 8));
  endfunction

  function automatic fill_e pick_fill();
    case ($urandom_range(0, 9))
      0:       return FillUp;
      1:       return FillDown;
      2:       return FillChecker;
      default: return FillRandom;
    endcase
  endfunction

  initial begin
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgWidth;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    spin_bit_i  <= 1'b0;
    calm        = 1'b0;
    in_jitter   = 1'b1;
    spins_sent  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: single-site lattices, where a spin bonds with itself
    set_size(11'd1, 11'd1);
    send_lattice(FillDown);
    send_lattice(FillUp);
    // zero sizes behave as one
    set_size(11'd0, 11'd0);
    send_lattice(FillUp);
    // 2x2 doubles every bond; pause mid-phase until the first result is out
    set_size(11'd2, 11'd2);
    send_lattice(FillUp);
    drain_results();
    send_lattice(FillChecker);
    // single row and single column
    set_size(11'd3, 11'd1);
    send_lattice(FillDown);
    set_size(11'd1, 11'd3);
    send_lattice(FillChecker);
    set_size(11'd2, 11'd3);
    send_lattice(FillRandom);

    // Random phases of small lattices, one to four lattices per size setting
    while (spins_sent < 700) begin
      w = pick_size();
      h = (w > 8) ? 11'($urandom_range(1, 4)) : pick_size();
      in_jitter = ($urandom_range(0, 9) < 7);
      set_size(w, h);
      repeat ($urandom_range(1, 4)) send_lattice(pick_fill());
    end

    // Closing stretch: longer rows and columns, with both sides streaming
    calm = 1'b1;
    drain_results();
    set_size(11'd64, 11'd2);
    send_lattice(FillUp);
    set_size(11'd48, 11'd1);
    send_lattice(FillRandom);
    set_size(11'd1, 11'd48);
    send_lattice(FillRandom);
    set_size(11'd1, 11'd32);
    send_lattice(FillDown);

    drain_results();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
